>>> hdl/kdaq_pkg.sv
// ----------------------------------------------------------------------------
// kdaq_pkg
// Shared types and constants of the key debounce, auto-repeat and code queue.
// ----------------------------------------------------------------------------
package kdaq_pkg;

   localparam int QUEUE_SLOTS_DEFAULT = 8;

   localparam int CODE_W     = 2;
   localparam int LEVEL_W    = 6;
   localparam int DEB_W      = 8;
   localparam int DELAY_W    = 10;
   localparam int REP_W      = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd3;
   localparam logic [DELAY_W-1:0] DELAY_RESET    = 10'd50;
   localparam logic [REP_W-1:0]   REPEAT_RESET   = 8'd15;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_DELAY    = 2'd1;
   localparam logic [1:0] CSR_REPEAT   = 2'd2;

   localparam logic [CODE_W-1:0] KEY_NONE = 2'd0;
   localparam logic [CODE_W-1:0] KEY_A    = 2'd1;
   localparam logic [CODE_W-1:0] KEY_B    = 2'd2;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [1:0] {
      PHASE_WAIT     = 2'd0,
      PHASE_DEBOUNCE = 2'd1,
      PHASE_INITIAL  = 2'd2,
      PHASE_REPEAT   = 2'd3
   } phase_type;

   // first member in the highest bits: key_code ends up lowest
   typedef struct packed {
      logic [LEVEL_W-1:0] queue_level;
      logic               code_dropped;
      logic               code_queued;
      logic [CODE_W-1:0]  key_code;
   } rsp_type;

endpackage

>>> hdl/key_debounce_autorepeat_queue_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_queue_unit
// Two-key debounce with initial delay, auto-repeat and a ring code queue.
// ----------------------------------------------------------------------------
// Each accepted item is either a tick that samples the two active-low key pins
// (tuser = 0) or a pop of the oldest queued code (tuser = 1), and gives exactly
// one result. The block takes one item per clock: the key machine, counters and
// queue pointers update in the accept cycle, and the result sits in an output
// register backed by a one-entry skid stage, so input is held off only while
// both are full. The code queue is a QUEUE_SLOTS-entry memory holding up to
// QUEUE_SLOTS-1 codes; its head entry is read ahead into a register so a pop
// answers in the same cycle. A code that finds the queue full is dropped and
// flagged in code_dropped. Registers: 0x0 debounce_ticks, 0x4
// initial_delay_ticks, 0x8 repeat_ticks; write them only while no result is
// pending.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_queue_unit
   import kdaq_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [0] key_a_level, [1] key_b_level, rest zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: [0] kind
   input  logic                  req_tuser,
   // rsp_tdata: [1:0] key_code, [2] code_queued, [3] code_dropped,
   //            [9:4] queue_level, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PTR_W = $clog2(QUEUE_SLOTS);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

   // configuration
   logic [DEB_W-1:0]   debounce_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [REP_W-1:0]   repeat_cfg_ff;
   logic               csr_write;

   // key machine
   phase_type          phase_ff, phase_in;
   logic [CODE_W-1:0]  held_ff, held_in;
   logic [DEB_W-1:0]   stable_ff, stable_in;
   logic [DELAY_W-1:0] hold_ff, hold_in;
   logic [REP_W-1:0]   rep_ff, rep_in;
   logic [CODE_W-1:0]  cur_code;
   logic               want_push;
   logic [DEB_W-1:0]   stable_inc;
   logic [DELAY_W-1:0] hold_inc;
   logic [REP_W-1:0]   rep_inc;

   // queue
   logic [CODE_W-1:0]  code_store [QUEUE_SLOTS];
   logic [CODE_W-1:0]  head_ff;
   logic [PTR_W-1:0]   rd_ff, rd_in, wr_ff, wr_in, rd_inc, wr_inc;
   logic               full, empty, push_ok, pop_ok;
   logic [LEVEL_W:0]   level_wide;

   // handshake and result
   logic               accept, tick_go, pop_go, out_take;
   rsp_type            result;
   rsp_type            out_ff, out_in, skid_ff, skid_in;
   logic               out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         delay_ff      <= DELAY_RESET;
         repeat_cfg_ff <= REPEAT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_DEBOUNCE: debounce_ff   <= csr_pwdata[DEB_W-1:0];
            CSR_DELAY:    delay_ff      <= csr_pwdata[DELAY_W-1:0];
            CSR_REPEAT:   repeat_cfg_ff <= csr_pwdata[REP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         CSR_DEBOUNCE: csr_prdata = CSR_DATA_W'(debounce_ff);
         CSR_DELAY:    csr_prdata = CSR_DATA_W'(delay_ff);
         CSR_REPEAT:   csr_prdata = CSR_DATA_W'(repeat_cfg_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- input
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign tick_go    = accept && (req_tuser == KIND_TICK);
   assign pop_go     = accept && (req_tuser == KIND_POP);

   always_comb begin
      if (!req_tdata[0]) begin
         cur_code = KEY_A;
      end else if (!req_tdata[1]) begin
         cur_code = KEY_B;
      end else begin
         cur_code = KEY_NONE;
      end
   end

   assign stable_inc = stable_ff + DEB_W'(1);
   assign hold_inc   = hold_ff + DELAY_W'(1);
   assign rep_inc    = rep_ff + REP_W'(1);

   // ---------------------------------------------------------------- key fsm
   always_comb begin
      phase_in = phase_ff;
      if (tick_go) begin
         unique case (phase_ff)
            PHASE_WAIT: begin
               if (cur_code != KEY_NONE) phase_in = PHASE_DEBOUNCE;
            end
            PHASE_DEBOUNCE: begin
               if (cur_code != held_ff) begin
                  phase_in = PHASE_WAIT;
               end else if (stable_inc >= debounce_ff) begin
                  phase_in = PHASE_INITIAL;
               end
            end
            PHASE_INITIAL: begin
               if (cur_code != held_ff) begin
                  phase_in = PHASE_WAIT;
               end else if (hold_inc >= delay_ff) begin
                  phase_in = PHASE_REPEAT;
               end
            end
            PHASE_REPEAT: begin
               if (cur_code != held_ff) phase_in = PHASE_WAIT;
            end
            default: phase_in = PHASE_WAIT;
         endcase
      end
   end

   always_comb begin
      held_in   = held_ff;
      stable_in = stable_ff;
      hold_in   = hold_ff;
      rep_in    = rep_ff;
      want_push = 1'b0;
      if (tick_go) begin
         unique case (phase_ff)
            PHASE_WAIT: begin
               if (cur_code != KEY_NONE) begin
                  held_in   = cur_code;
                  stable_in = '0;
               end
            end
            PHASE_DEBOUNCE: begin
               if (cur_code == held_ff) begin
                  stable_in = stable_inc;
                  if (stable_inc >= debounce_ff) hold_in = '0;
               end
            end
            PHASE_INITIAL: begin
               if (cur_code != held_ff) begin
                  want_push = (cur_code == KEY_NONE);
               end else begin
                  hold_in = hold_inc;
                  if (hold_inc >= delay_ff) begin
                     want_push = 1'b1;
                     rep_in    = '0;
                  end
               end
            end
            PHASE_REPEAT: begin
               if (cur_code == held_ff) begin
                  if (rep_inc >= repeat_cfg_ff) begin
                     want_push = 1'b1;
                     rep_in    = '0;
                  end else begin
                     rep_in = rep_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_WAIT;
         held_ff   <= KEY_NONE;
         stable_ff <= '0;
         hold_ff   <= '0;
         rep_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         stable_ff <= stable_in;
         hold_ff   <= hold_in;
         rep_ff    <= rep_in;
      end
   end

   // ---------------------------------------------------------------- queue
   assign rd_inc  = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PTR_W'(1);
   assign wr_inc  = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PTR_W'(1);
   assign full    = (wr_inc == rd_ff);
   assign empty   = (rd_ff == wr_ff);
   assign push_ok = want_push && !full;
   assign pop_ok  = pop_go && !empty;
   assign rd_in   = pop_ok ? rd_inc : rd_ff;
   assign wr_in   = push_ok ? wr_inc : wr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end

   // read the next head ahead; forward a write to that same slot
   always_ff @(posedge clock) begin
      if (push_ok) code_store[wr_ff] <= held_ff;
      if (push_ok && (wr_ff == rd_in)) begin
         head_ff <= held_ff;
      end else begin
         head_ff <= code_store[rd_in];
      end
   end

   always_comb begin
      level_wide = (LEVEL_W + 1)'(wr_in) - (LEVEL_W + 1)'(rd_in);
      if (wr_in < rd_in) level_wide = level_wide + (LEVEL_W + 1)'(QUEUE_SLOTS);
   end

   always_comb begin
      result.key_code     = pop_ok ? head_ff : KEY_NONE;
      result.code_queued  = push_ok;
      result.code_dropped = want_push && full;
      result.queue_level  = level_wide[LEVEL_W-1:0];
   end

   // ---------------------------------------------------------------- output
   assign out_take = out_valid_ff && rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_queued_or_dropped: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.code_queued && out_ff.code_dropped))
      else $error("code both queued and dropped");

   a_push_phase: assert property (@(posedge clock) disable iff (reset)
      want_push |-> (phase_ff == PHASE_INITIAL || phase_ff == PHASE_REPEAT))
      else $error("code pushed outside initial delay or repeat");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> (level_wide < (LEVEL_W + 1)'(QUEUE_SLOTS)))
      else $error("queue level beyond capacity");

   a_pop_moves_read: assert property (@(posedge clock) disable iff (reset)
      pop_ok |=> (rd_ff != $past(rd_ff)))
      else $error("pop did not advance the read slot");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level regression of the two-key debounce, auto-repeat and code queue.
// ----------------------------------------------------------------------------
// Tick and pop transfers go in on the req_ stream, and every response on the
// rsp_ stream is compared field by field against an in-order model of the key
// machine and the ring queue. The run first uses the reset register values,
// then a short directed sequence, then random press, bounce, key-switch and
// release sequences under several register settings, zero and full scale
// among them. Both stream sides idle in random bursts. The receiver also holds
// off once for a long stretch, so the output and skid fill and input stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kdaq_pkg::*;

   localparam int QUEUE_SLOTS  = QUEUE_SLOTS_DEFAULT;
   localparam int RSP_BITS     = $bits(rsp_type);
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 20;

   class key_code_tracker;
      logic [DEB_W-1:0]   debounce_ticks;
      logic [DELAY_W-1:0] delay_ticks;
      logic [REP_W-1:0]   repeat_ticks;
      phase_type          key_phase;
      logic [CODE_W-1:0]  held_code;
      logic [DEB_W-1:0]   stable_count;
      logic [DELAY_W-1:0] hold_count;
      logic [REP_W-1:0]   repeat_count;
      logic [CODE_W-1:0]  code_ring[QUEUE_SLOTS];
      int                 rd_slot;
      int                 wr_slot;
      rsp_type            pending_results[$];
      int mismatches, n_ticks, n_pops, n_queued, n_repeats, n_dropped, n_empty_pops;
      int peak_level;

      function new();
         debounce_ticks = DEBOUNCE_RESET;
         delay_ticks    = DELAY_RESET;
         repeat_ticks   = REPEAT_RESET;
         key_phase      = PHASE_WAIT;
         held_code      = KEY_NONE;
         stable_count   = '0;
         hold_count     = '0;
         repeat_count   = '0;
         rd_slot        = 0;
         wr_slot        = 0;
         mismatches     = 0;
         n_ticks        = 0;
         n_pops         = 0;
         n_queued       = 0;
         n_repeats      = 0;
         n_dropped      = 0;
         n_empty_pops   = 0;
         peak_level     = 0;
      endfunction

      function int queue_depth();
         if (wr_slot >= rd_slot) return wr_slot - rd_slot;
         return QUEUE_SLOTS - rd_slot + wr_slot;
      endfunction

      function void write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DEBOUNCE: debounce_ticks = value[DEB_W-1:0];
            CSR_DELAY:    delay_ticks    = value[DELAY_W-1:0];
            CSR_REPEAT:   repeat_ticks   = value[REP_W-1:0];
            default:      ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] read_reg(logic [1:0] idx);
         case (idx)
            CSR_DEBOUNCE: return CSR_DATA_W'(debounce_ticks);
            CSR_DELAY:    return CSR_DATA_W'(delay_ticks);
            CSR_REPEAT:   return CSR_DATA_W'(repeat_ticks);
            default:      return '0;
         endcase
      endfunction

      function void predict_item(logic kind, logic [REQ_DATA_W-1:0] data);
         rsp_type           exp_rsp;
         logic [CODE_W-1:0] cur;
         logic              push;
         logic              from_repeat;
         int                nxt;
         exp_rsp     = '0;
         push        = 1'b0;
         from_repeat = 1'b0;
         if (kind == KIND_POP) begin
            n_pops++;
            if (rd_slot != wr_slot) begin
               exp_rsp.key_code = code_ring[rd_slot];
               rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
            end else begin
               n_empty_pops++;
            end
         end else begin
            n_ticks++;
            cur = !data[0] ? KEY_A : (!data[1] ? KEY_B : KEY_NONE);
            case (key_phase)
               PHASE_WAIT: begin
                  if (cur != KEY_NONE) begin
                     held_code    = cur;
                     stable_count = '0;
                     key_phase    = PHASE_DEBOUNCE;
                  end
               end
               PHASE_DEBOUNCE: begin
                  if (cur != held_code) begin
                     key_phase = PHASE_WAIT;
                  end else begin
                     stable_count = stable_count + 1'b1;
                     if (stable_count >= debounce_ticks) begin
                        hold_count = '0;
                        key_phase  = PHASE_INITIAL;
                     end
                  end
               end
               PHASE_INITIAL: begin
                  if (cur != held_code) begin
                     push      = (cur == KEY_NONE);
                     key_phase = PHASE_WAIT;
                  end else begin
                     hold_count = hold_count + 1'b1;
                     if (hold_count >= delay_ticks) begin
                        push         = 1'b1;
                        repeat_count = '0;
                        key_phase    = PHASE_REPEAT;
                     end
                  end
               end
               default: begin
                  if (cur != held_code) begin
                     key_phase = PHASE_WAIT;
                  end else begin
                     repeat_count = repeat_count + 1'b1;
                     if (repeat_count >= repeat_ticks) begin
                        push         = 1'b1;
                        from_repeat  = 1'b1;
                        repeat_count = '0;
                     end
                  end
               end
            endcase
            if (push) begin
               nxt = (wr_slot + 1) % QUEUE_SLOTS;
               if (nxt == rd_slot) begin
                  exp_rsp.code_dropped = 1'b1;
                  n_dropped++;
               end else begin
                  code_ring[wr_slot]  = held_code;
                  wr_slot             = nxt;
                  exp_rsp.code_queued = 1'b1;
                  n_queued++;
                  if (from_repeat) n_repeats++;
               end
            end
         end
         exp_rsp.queue_level = LEVEL_W'(queue_depth());
         if (queue_depth() > peak_level) peak_level = queue_depth();
         pending_results.push_back(exp_rsp);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task compare_result(logic [RSP_DATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = data[RSP_BITS-1:0];
         if (pending_results.size() == 0) begin
            report($sformatf("response %h with nothing outstanding", data));
            return;
         end
         want = pending_results.pop_front();
         if (got.key_code != want.key_code)
            report($sformatf("key_code %0d, expected %0d", got.key_code, want.key_code));
         if (got.code_queued != want.code_queued)
            report($sformatf("code_queued %0b, expected %0b", got.code_queued,
                             want.code_queued));
         if (got.code_dropped != want.code_dropped)
            report($sformatf("code_dropped %0b, expected %0b", got.code_dropped,
                             want.code_dropped));
         if (got.queue_level != want.queue_level)
            report($sformatf("queue_level %0d, expected %0d", got.queue_level,
                             want.queue_level));
         if (data[RSP_DATA_W-1:RSP_BITS] != '0)
            report($sformatf("nonzero padding in response %h", data));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   key_code_tracker tracker;
   int src_idle_pct;
   int sink_stall_pct;
   int hold_off_cycles;
   int items_sent;
   int quiet_cycles;
   int settings_used;

   key_debounce_autorepeat_queue_unit #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.predict_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.compare_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("key_debounce_autorepeat_queue_unit regression: fail");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_cycles > 0) begin
            n               = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if ($urandom_range(99) < sink_stall_pct) begin
            n = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(logic kind, logic a_level, logic b_level);
      int gap;
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-2){1'b0}}, b_level, a_level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic tick_pins(logic a_level, logic b_level);
      send_item(KIND_TICK, a_level, b_level);
   endtask

   task automatic pop_code();
      send_item(KIND_POP, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic tick_or_pop(int pop_pct, logic a_level, logic b_level);
      if ($urandom_range(99) < pop_pct) pop_code();
      else tick_pins(a_level, b_level);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_reg(idx, value);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != tracker.read_reg(idx))
         tracker.report($sformatf("register %0d reads %h, expected %h", idx, readback,
                                  tracker.read_reg(idx)));
      @(posedge clock);
   endtask

   task automatic configure(int deb, int delay, int rep);
      drain_results();
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_DELAY, delay);
      write_reg(CSR_REPEAT, rep);
      settings_used++;
   endtask

   task automatic press_sequence(int pop_pct, int min_hold, int max_hold);
      logic pa;
      logic pb;
      int   n;
      case ($urandom_range(2))
         0:       begin pa = 1'b0; pb = 1'b1; end
         1:       begin pa = 1'b1; pb = 1'b0; end
         default: begin pa = 1'b0; pb = 1'b0; end
      endcase
      if ($urandom_range(3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            tick_pins(pa, pb);
            tick_pins(1'b1, 1'b1);
         end
      end
      n = $urandom_range(min_hold, max_hold);
      repeat (n) tick_or_pop(pop_pct, pa, pb);
      if ($urandom_range(9) < 2) begin
         n = $urandom_range(1, 5);
         repeat (n) begin
            if (!pa) tick_pins(1'b1, 1'b0);
            else tick_pins(1'b0, 1'b1);
         end
      end
      n = $urandom_range(1, 8);
      repeat (n) tick_or_pop(pop_pct, 1'b1, 1'b1);
   endtask

   task automatic run_random(int count, int pop_pct, int min_hold, int max_hold);
      int start;
      int n;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(99) < 80) begin
            press_sequence(pop_pct, min_hold, max_hold);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n)
               tick_or_pop(pop_pct, 1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
   endtask

   // run with debounce 2, initial delay 2+1, repeat 2
   task automatic directed_sequence();
      send_item(KIND_POP, 1'b0, 1'b0);
      tick_pins(1'b1, 1'b1);
      tick_pins(1'b0, 1'b1);
      tick_pins(1'b1, 1'b0);
      tick_pins(1'b1, 1'b0);
      tick_pins(1'b1, 1'b0);
      send_item(KIND_POP, 1'b1, 1'b1);
      tick_pins(1'b1, 1'b0);
      tick_pins(1'b1, 1'b1);
      tick_pins(1'b0, 1'b1);
      tick_pins(1'b0, 1'b1);
      tick_pins(1'b0, 1'b1);
      tick_pins(1'b1, 1'b0);
      repeat (8) tick_pins(1'b0, 1'b0);
      tick_pins(1'b1, 1'b0);
      repeat (4) send_item(KIND_POP, 1'b1, 1'b0);
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = KIND_TICK;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      src_idle_pct    = 15;
      sink_stall_pct  = 15;
      hold_off_cycles = 0;
      items_sent      = 0;
      quiet_cycles    = 0;
      settings_used   = 1;
      tracker         = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_random(200, 10, 1, 120);

      configure(2, 3, 2);
      directed_sequence();

      src_idle_pct   = 30;
      sink_stall_pct = 30;
      configure(0, 0, 0);
      run_random(200, 20, 1, 20);

      src_idle_pct   = 5;
      sink_stall_pct = 40;
      configure(1, 1, 1);
      run_random(200, 35, 1, 15);

      src_idle_pct   = 10;
      sink_stall_pct = 10;
      configure(1, 2, 1);
      hold_off_cycles = 80;
      run_random(200, 5, 1, 30);

      src_idle_pct   = 15;
      sink_stall_pct = 15;
      configure(255, 1, 255);
      run_random(100, 10, 240, 300);

      src_idle_pct   = 40;
      sink_stall_pct = 5;
      configure(1, 1023, 1);
      run_random(100, 10, 20, 150);

      src_idle_pct   = 0;
      sink_stall_pct = 0;
      configure(5, 20, 6);
      run_random(150, 15, 5, 60);

      drain_results();

      $display("covered %0d ticks and %0d pops under %0d register settings",
               tracker.n_ticks, tracker.n_pops, settings_used);
      $display("%0d codes queued (%0d by auto-repeat), %0d dropped, %0d empty pops, peak %0d",
               tracker.n_queued, tracker.n_repeats, tracker.n_dropped,
               tracker.n_empty_pops, tracker.peak_level);
      if (tracker.mismatches == 0) begin
         $display("key_debounce_autorepeat_queue_unit regression: pass");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("key_debounce_autorepeat_queue_unit regression: fail");
      end
      $finish;
   end

endmodule
